@@ rtl/rpcg_pkg.sv @@
// Shared constants, types and helpers for the Raptor precode column generator.
`timescale 1ns / 1ps

package rpcg_pkg;

    localparam int COL_W     = 14;
    localparam int S_W       = 8;
    localparam int H_W       = 5;
    localparam int MASK_W    = 16;
    localparam int ONES_W    = 5;
    localparam int WEIGHT_W  = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 14;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 72;

    localparam int MAX_HALF_ROWS = 16;
    localparam int MAX_SOURCE    = 8192;

    // iterative divider: one quotient bit per cycle
    localparam int DIV_STEPS = COL_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_K_SOURCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_S_LDPC   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_H_HALF   = 2'd2;

    localparam logic [COL_W-1:0] K_SOURCE_RST = 14'd4;
    localparam logic [S_W-1:0]   S_LDPC_RST   = 8'd5;
    localparam logic [H_W-1:0]   H_HALF_RST   = 5'd5;

    typedef struct packed {
        logic             done;
        logic [COL_W-1:0] quo;
        logic [S_W-1:0]   rem;
    } t_div_result;

    typedef struct packed {
        logic              done;
        logic [MASK_W-1:0] word;
    } t_gray_result;

    function automatic logic [ONES_W-1:0] pop16(input logic [MASK_W-1:0] v);
        logic [ONES_W-1:0] acc;
        acc = '0;
        for (int i = 0; i < MASK_W; i++) begin
            acc = acc + ONES_W'(v[i]);
        end
        return acc;
    endfunction

endpackage

@@ rtl/rpcg_divider.sv @@
// Restoring divider, one quotient bit per cycle, shared by both LDPC divisions.
`timescale 1ns / 1ps

module rpcg_divider (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [rpcg_pkg::COL_W-1:0] i_dividend,
    input  logic [rpcg_pkg::S_W-1:0]   i_divisor,
    output rpcg_pkg::t_div_result      o_result
);
    import rpcg_pkg::*;

    logic [S_W-1:0]       r_rem;
    logic [COL_W-1:0]     r_quo;
    logic [S_W-1:0]       r_div;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [S_W:0] trial;
    logic [S_W:0] diff;
    logic         fits;

    assign trial = {r_rem, r_quo[COL_W-1]};
    assign fits  = trial >= {1'b0, r_div};
    assign diff  = trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_STEPS - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // payload: shift dividend out, quotient bits in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? diff[S_W-1:0] : trial[S_W-1:0];
            r_quo <= {r_quo[COL_W-2:0], fits};
        end
    end

    assign o_result.done = r_done;
    assign o_result.quo  = r_quo;
    assign o_result.rem  = r_rem;

endmodule

@@ rtl/rpcg_gray_search.sv @@
// Gray counter that walks forward until a code word of the wanted weight appears.
`timescale 1ns / 1ps

module rpcg_gray_search (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_clear,
    input  logic                          i_start,
    input  logic [rpcg_pkg::WEIGHT_W-1:0] i_weight,
    output rpcg_pkg::t_gray_result        o_result
);
    import rpcg_pkg::*;

    logic [MASK_W-1:0] r_gray;
    logic [MASK_W-1:0] r_word;
    logic              r_busy;
    logic              r_done;

    logic [MASK_W-1:0] code;
    logic              hit;

    assign code = r_gray ^ (r_gray >> 1);
    assign hit  = pop16(code) == ONES_W'(i_weight);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gray <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_clear) begin
                r_gray <= '0;
            end else if (r_busy) begin
                // advance past every word tried, the hit too
                r_gray <= r_gray + 1'b1;
                if (hit) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
            if (i_start) begin
                r_busy <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy && hit) begin
            r_word <= code;
        end
    end

    assign o_result.done = r_done;
    assign o_result.word = r_word;

endmodule

@@ rtl/raptor_precode_column_generator_unit.sv @@
// Top level of the Raptor precode column generator: sequencer, registers, output stage.
`timescale 1ns / 1ps

// Channel   | Dir | Signals                       | Contents
// ----------+-----+-------------------------------+-----------------------------------
// s         | in  | i_s_tvalid/o_s_tready/i_s_tdata | column request, restart flag
// m         | out | o_m_tvalid/i_m_tready/o_m_tdata | one constraint column description
// cfg       | in  | i_cfg_valid/o_cfg_ready/idx/data | K, S, H registers
//
// One column at a time. A bad column or one at or above K+S goes from the check
// state straight to the finish state. A column in K..K+S-1 runs the Gray search;
// a column below K first makes two passes of the shared bit-serial divider
// (column / S, then quotient mod S-1) and then the Gray search, which tries
// one 16-bit code word per cycle until it finds one of weight ceil(H/2).
// Synchronous active-low reset clears the sequencer, Gray counter, expected
// column and registers (K=4, S=5, H=5). The input is ready only in idle; the
// result register holds a finished column while the sink stalls, so the next
// request can be taken meanwhile.
module raptor_precode_column_generator_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // [13:0] column, [14] restart, [15] zero
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [rpcg_pkg::S_TDATA_W-1:0] i_s_tdata,
    // [13:0] column_echo, [14] ldpc_present, [22:15] ldpc_row_a,
    // [30:23] ldpc_row_b, [38:31] ldpc_row_c, [54:39] half_mask,
    // [55] identity_present, [63:56] identity_row, [68:64] ones_count,
    // [69] bad_column, [71:70] zero
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [rpcg_pkg::M_TDATA_W-1:0] o_m_tdata,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [rpcg_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rpcg_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import rpcg_pkg::*;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_CHECK    = 3'd1;
    localparam logic [2:0] ST_DIV_COL  = 3'd2;
    localparam logic [2:0] ST_DIV_STEP = 3'd3;
    localparam logic [2:0] ST_ROW_C    = 3'd4;
    localparam logic [2:0] ST_GRAY     = 3'd5;
    localparam logic [2:0] ST_FINISH   = 3'd6;

    // configuration registers
    logic [COL_W-1:0] r_k_source;
    logic [S_W-1:0]   r_s_ldpc;
    logic [H_W-1:0]   r_h_half;

    logic [2:0]       r_state;
    logic [2:0]       n_state;
    logic [COL_W-1:0] r_expect_col;

    // working registers of the column in flight
    logic [COL_W-1:0]  r_col;
    logic              r_bad;
    logic              r_ldpc;
    logic [S_W-1:0]    r_ra;
    logic [S_W-1:0]    r_rb;
    logic [S_W-1:0]    r_rc;
    logic [S_W-1:0]    r_step;
    logic [MASK_W-1:0] r_mask;
    logic              r_ident;
    logic [7:0]        r_idrow;
    logic [ONES_W-1:0] r_ones;

    logic                 r_m_valid;
    logic [M_TDATA_W-1:0] r_m_data;

    // effective parameters
    logic [COL_W-1:0]    kk;
    logic [H_W-1:0]      hh;
    logic [S_W-1:0]      sm;
    logic [S_W-1:0]      sm1;
    logic [COL_W:0]      ks;
    logic [COL_W:0]      ll;
    logic [MASK_W-1:0]   hmask;
    logic [WEIGHT_W-1:0] weight;

    logic s_xfer;
    logic cfg_xfer;
    logic col_bad;
    logic lt_k;
    logic lt_ks;
    logic out_free;

    logic             div_start;
    logic [COL_W-1:0] div_dividend;
    logic [S_W-1:0]   div_divisor;
    t_div_result      div_res;

    logic         gray_start;
    logic         gray_clear;
    t_gray_result gray_res;

    logic [S_W:0]      sum_b;
    logic [S_W-1:0]    rb_mod;
    logic [S_W:0]      sum_c;
    logic [S_W-1:0]    rc_mod;
    logic [ONES_W-1:0] ldpc_ones;

    assign kk     = (r_k_source > COL_W'(MAX_SOURCE)) ? COL_W'(MAX_SOURCE) : r_k_source;
    assign hh     = (r_h_half > H_W'(MAX_HALF_ROWS)) ? H_W'(MAX_HALF_ROWS) : r_h_half;
    assign sm     = (r_s_ldpc == '0) ? S_W'(1) : r_s_ldpc;
    assign sm1    = (r_s_ldpc < S_W'(2)) ? S_W'(1) : r_s_ldpc - 1'b1;
    assign ks     = {1'b0, kk} + (COL_W + 1)'(r_s_ldpc);
    assign ll     = ks + (COL_W + 1)'(hh);
    assign hmask  = (hh >= H_W'(MASK_W)) ? '1 : MASK_W'((17'd1 << hh) - 17'd1);
    assign weight = WEIGHT_W'((6'(hh) + 6'd1) >> 1);

    assign o_s_tready  = (r_state == ST_IDLE);
    assign s_xfer      = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;
    assign cfg_xfer    = i_cfg_valid && o_cfg_ready;
    assign out_free    = !r_m_valid || i_m_tready;

    assign col_bad = ({1'b0, r_col} >= ll) || (r_col != r_expect_col);
    assign lt_k    = r_col < kk;
    assign lt_ks   = {1'b0, r_col} < ks;

    // LDPC rows: add the step and fold once, as the sum stays below twice the modulus
    assign sum_b     = {1'b0, r_ra} + {1'b0, div_res.rem} + 1'b1;
    assign rb_mod    = (sum_b >= {1'b0, sm}) ? S_W'(sum_b - {1'b0, sm}) : sum_b[S_W-1:0];
    assign sum_c     = {1'b0, r_rb} + {1'b0, r_step};
    assign rc_mod    = (sum_c >= {1'b0, sm}) ? S_W'(sum_c - {1'b0, sm}) : sum_c[S_W-1:0];
    assign ldpc_ones = ONES_W'(1) + ONES_W'(r_rb != r_ra)
                     + ONES_W'((rc_mod != r_ra) && (rc_mod != r_rb));

    assign div_start    = ((r_state == ST_CHECK) && !col_bad && lt_k)
                       || ((r_state == ST_DIV_COL) && div_res.done);
    assign div_dividend = (r_state == ST_CHECK) ? r_col : div_res.quo;
    assign div_divisor  = (r_state == ST_CHECK) ? sm : sm1;

    assign gray_clear = s_xfer && i_s_tdata[COL_W];
    assign gray_start = ((r_state == ST_CHECK) && !col_bad && !lt_k && lt_ks)
                     || (r_state == ST_ROW_C);

    rpcg_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_result   (div_res)
    );

    rpcg_gray_search u_gray_search (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (gray_clear),
        .i_start  (gray_start),
        .i_weight (weight),
        .o_result (gray_res)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_xfer) n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (col_bad)    n_state = ST_FINISH;
                else if (lt_k)  n_state = ST_DIV_COL;
                else if (lt_ks) n_state = ST_GRAY;
                else            n_state = ST_FINISH;
            end
            ST_DIV_COL: begin
                if (div_res.done) n_state = ST_DIV_STEP;
            end
            ST_DIV_STEP: begin
                if (div_res.done) n_state = ST_ROW_C;
            end
            ST_ROW_C: begin
                n_state = ST_GRAY;
            end
            ST_GRAY: begin
                if (gray_res.done) n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_expect_col <= '0;
            r_k_source   <= K_SOURCE_RST;
            r_s_ldpc     <= S_LDPC_RST;
            r_h_half     <= H_HALF_RST;
            r_m_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            // restart clears the expected column before the check
            if (s_xfer && i_s_tdata[COL_W]) begin
                r_expect_col <= '0;
            end else if ((r_state == ST_CHECK) && !col_bad) begin
                r_expect_col <= r_expect_col + 1'b1;
            end
            if (cfg_xfer) begin
                unique case (i_cfg_index)
                    REG_K_SOURCE: r_k_source <= i_cfg_data;
                    REG_S_LDPC:   r_s_ldpc   <= i_cfg_data[S_W-1:0];
                    REG_H_HALF:   r_h_half   <= i_cfg_data[H_W-1:0];
                    default:      ;
                endcase
            end
            if ((r_state == ST_FINISH) && out_free) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // datapath of the column in flight
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (s_xfer) r_col <= i_s_tdata[COL_W-1:0];
            end
            ST_CHECK: begin
                r_bad   <= col_bad;
                r_ldpc  <= !col_bad && lt_k;
                r_ra    <= '0;
                r_rb    <= '0;
                r_rc    <= '0;
                r_mask  <= '0;
                r_ident <= !col_bad && !lt_k;
                r_idrow <= (!col_bad && !lt_k) ? 8'(r_col - kk) : 8'd0;
                r_ones  <= (!col_bad && !lt_k) ? ONES_W'(1) : ONES_W'(0);
            end
            ST_DIV_COL: begin
                if (div_res.done) r_ra <= div_res.rem;
            end
            ST_DIV_STEP: begin
                if (div_res.done) begin
                    r_step <= div_res.rem + 1'b1;
                    r_rb   <= rb_mod;
                end
            end
            ST_ROW_C: begin
                r_rc   <= rc_mod;
                r_ones <= ldpc_ones;
            end
            ST_GRAY: begin
                if (gray_res.done) begin
                    r_mask <= gray_res.word & hmask;
                    r_ones <= r_ones + pop16(gray_res.word & hmask);
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    r_m_data <= {2'b00, r_bad, r_ones, r_idrow, r_ident, r_mask,
                                 r_rc, r_rb, r_ra, r_ldpc, r_col};
                end
            end
            default: ;
        endcase
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

endmodule

@@ test/tb_raptor_precode_column_generator_unit.sv @@
// Self-checking testbench for the Raptor precode column generator unit.
`timescale 1ns / 1ps

module tb_raptor_precode_column_generator_unit;

    import rpcg_pkg::*;

    // Total input transfers to aim for; the last eighth runs with no idling.
    localparam int unsigned ITEM_TARGET     = 1800;
    // Long sink hold-off so that the result register fills and the input stalls.
    localparam int unsigned HOLD_OFF_CYCLES = 120;
    // Idle pause once every result is in, ahead of a register write.
    localparam int unsigned SETTLE_CYCLES   = 4;
    // Idle tail after the last result, ahead of the verdict.
    localparam int unsigned TAIL_CYCLES     = 60;
    // Hard stop: the weight-zero search alone walks the whole 16-bit Gray counter.
    localparam int unsigned RUN_LIMIT_NS    = 40_000_000;

    // Index that decodes to no register; writes to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    localparam int unsigned NUM_PRIMES = 12;
    localparam int unsigned LDPC_PRIMES [0:NUM_PRIMES-1] =
        '{5, 7, 11, 13, 17, 19, 23, 29, 37, 53, 101, 211};

    // Result transfer as it sits on o_m_tdata, highest bits first.
    typedef struct packed {
        logic [1:0]        spare;
        logic              bad;
        logic [ONES_W-1:0] ones;
        logic [S_W-1:0]    id_row;
        logic              id_on;
        logic [MASK_W-1:0] mask;
        logic [S_W-1:0]    rc;
        logic [S_W-1:0]    rb;
        logic [S_W-1:0]    ra;
        logic              ldpc_on;
        logic [COL_W-1:0]  col;
    } t_column_word;

    // How a directed row gets its expectation.
    typedef enum logic [1:0] {
        ROW_PREDICT,   // from the predictor
        ROW_FIRST,     // column zero at reset settings, typed below
        ROW_REJECT     // echo plus bad_column, nothing else
    } t_row_kind;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic             restart;
        t_row_kind        kind;
    } t_probe;

    // Column zero with K=4, S=5, H=5 and a fresh Gray counter: rows 0, 1, 2 and
    // the first weight-3 Gray word, 0b00111, so six ones in all.
    localparam t_column_word FIRST_COLUMN = '{
        default: '0,
        ldpc_on: 1'b1,
        ra:      8'd0,
        rb:      8'd1,
        rc:      8'd2,
        mask:    16'h0007,
        ones:    5'd6
    };

    localparam int unsigned NUM_PROBES = 22;
    localparam t_probe PROBES [0:NUM_PROBES-1] = '{
        '{14'd0,     1'b0, ROW_FIRST},    // reset settings, counter at zero
        '{14'd5,     1'b0, ROW_REJECT},   // out of order
        '{14'd16383, 1'b0, ROW_REJECT},   // every column bit high
        '{14'd1,     1'b0, ROW_PREDICT},
        '{14'd2,     1'b0, ROW_PREDICT},
        '{14'd3,     1'b0, ROW_PREDICT},
        '{14'd4,     1'b0, ROW_PREDICT},  // first Half/identity column
        '{14'd5,     1'b0, ROW_PREDICT},
        '{14'd6,     1'b0, ROW_PREDICT},
        '{14'd7,     1'b0, ROW_PREDICT},
        '{14'd8,     1'b0, ROW_PREDICT},
        '{14'd9,     1'b0, ROW_PREDICT},  // identity only from here
        '{14'd10,    1'b0, ROW_PREDICT},
        '{14'd11,    1'b0, ROW_PREDICT},
        '{14'd12,    1'b0, ROW_PREDICT},
        '{14'd13,    1'b0, ROW_PREDICT},  // last column, L - 1
        '{14'd14,    1'b0, ROW_REJECT},   // column equal to L
        '{14'd0,     1'b1, ROW_FIRST},    // restart replays column zero
        '{14'd3,     1'b1, ROW_REJECT},   // restart clears, then rejects
        '{14'd0,     1'b0, ROW_FIRST},    // rejected restart still cleared state
        '{14'd1,     1'b0, ROW_PREDICT},
        '{14'd0,     1'b0, ROW_REJECT}    // going backwards
    };

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata;
    logic                 o_m_tvalid;
    logic                 i_m_tready;
    logic [M_TDATA_W-1:0] o_m_tdata;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_data;

    // Predictor state and its copy of the registers.
    logic [MASK_W-1:0] gray_pos   = '0;
    logic [COL_W-1:0]  expect_col = '0;
    logic [COL_W-1:0]  k_cfg      = K_SOURCE_RST;
    logic [S_W-1:0]    s_cfg      = S_LDPC_RST;
    logic [H_W-1:0]    h_cfg      = H_HALF_RST;

    // Column descriptions still owed by the block, oldest first.
    t_column_word awaited_columns [$];

    int unsigned items_sent   = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches   = 0;
    int unsigned squeeze_at   = 200;
    int unsigned send_quiet   = 0;
    bit          calm         = 1'b0;   // no idling on either side
    bit          flowing      = 1'b0;   // a column walk is under way

    raptor_precode_column_generator_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin : clock_gen
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("TB_ERROR");
        $finish;
    end

    // Effective K and H: oversized registers are clipped to the maxima.
    function automatic int unsigned eff_k();
        return (k_cfg > MAX_SOURCE) ? MAX_SOURCE : k_cfg;
    endfunction

    function automatic int unsigned eff_h();
        return (h_cfg > MAX_HALF_ROWS) ? MAX_HALF_ROWS : h_cfg;
    endfunction

    function automatic int unsigned frame_len();
        return eff_k() + s_cfg + eff_h();
    endfunction

    // Work out the column description for one accepted request and advance the
    // Gray search and the expected column exactly as the block must.
    function automatic t_column_word derive_column(input logic [COL_W-1:0] col,
                                                   input logic restart);
        t_column_word      w;
        int unsigned       kk, ss, hh, sm, sm1, stride, weight, ones;
        logic [MASK_W-1:0] code, hmask;
        w = '0;
        w.col = col;
        kk = eff_k();
        ss = s_cfg;
        hh = eff_h();
        if (restart) begin
            gray_pos   = '0;
            expect_col = '0;
        end
        // Rejected columns leave the state alone.
        if (col >= frame_len() || col != expect_col) begin
            w.bad = 1'b1;
            return w;
        end
        expect_col = expect_col + 1'b1;
        ones = 0;
        if (col < kk) begin
            // S of 0 or 1 degenerates to modulus 1 and a step of 1.
            sm     = (ss == 0) ? 1 : ss;
            sm1    = (ss < 2) ? 1 : ss - 1;
            stride = 1 + ((col / sm) % sm1);
            w.ldpc_on = 1'b1;
            w.ra = S_W'(col % sm);
            w.rb = S_W'((w.ra + stride) % sm);
            w.rc = S_W'((w.rb + stride) % sm);
            ones = 1 + (w.rb != w.ra) + ((w.rc != w.ra) && (w.rc != w.rb));
        end
        if (col < kk + ss) begin
            // Walk the Gray counter until a word of weight ceil(H/2) turns up.
            weight = (hh + 1) / 2;
            do begin
                code     = gray_pos ^ (gray_pos >> 1);
                gray_pos = gray_pos + 1'b1;
            end while ($countones(code) != weight);
            hmask  = (hh >= 16) ? 16'hFFFF : MASK_W'((32'd1 << hh) - 1);
            w.mask = code & hmask;
            ones   = ones + $countones(w.mask);
        end
        if (col >= kk) begin
            w.id_on  = 1'b1;
            w.id_row = S_W'(col - kk);
            ones     = ones + 1;
        end
        w.ones = ONES_W'(ones);
        return w;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Compare each result transfer with the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_column_word got, want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = t_column_word'(o_m_tdata);
            results_seen++;
            if (awaited_columns.size() == 0) begin
                $error("column_echo: expected no result, got %0d", got.col);
                mismatches++;
            end else begin
                want = awaited_columns.pop_front();
                check_field("column_echo", 32'(want.col), 32'(got.col));
                check_field("ldpc_present", 32'(want.ldpc_on), 32'(got.ldpc_on));
                check_field("ldpc_row_a", 32'(want.ra), 32'(got.ra));
                check_field("ldpc_row_b", 32'(want.rb), 32'(got.rb));
                check_field("ldpc_row_c", 32'(want.rc), 32'(got.rc));
                check_field("half_mask", 32'(want.mask), 32'(got.mask));
                check_field("identity_present", 32'(want.id_on), 32'(got.id_on));
                check_field("identity_row", 32'(want.id_row), 32'(got.id_row));
                check_field("ones_count", 32'(want.ones), 32'(got.ones));
                check_field("bad_column", 32'(want.bad), 32'(got.bad));
            end
        end
    end

    // Sink side: short random stalls, quiet stretches, and a long hold-off now
    // and then while a walk is running so the block backs up into its input.
    initial begin : result_sink
        int unsigned stall_left, quiet_left;
        stall_left = 0;
        quiet_left = 0;
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (calm) begin
                stall_left = 0;
                quiet_left = 0;
            end else if (flowing && results_seen >= squeeze_at) begin
                squeeze_at = squeeze_at + 700;
                stall_left = HOLD_OFF_CYCLES;
            end else if (stall_left == 0 && quiet_left == 0) begin
                case ($urandom_range(0, 15))
                    0, 1: stall_left = $urandom_range(1, 6);
                    2: quiet_left = $urandom_range(20, 80);
                    default: ;
                endcase
            end else if (quiet_left > 0) begin
                quiet_left--;
            end
            if (stall_left > 0) begin
                i_m_tready <= 1'b0;
                stall_left--;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Offer one column request, hold it until the transfer, then record what
    // the block owes for it.
    task automatic offer(input logic [COL_W-1:0] col, input logic restart,
                         input t_row_kind kind);
        t_column_word want;
        int unsigned  pick;
        if (!calm) begin
            if (send_quiet > 0) begin
                send_quiet--;
            end else begin
                pick = $urandom_range(0, 15);
                if (pick < 2) begin
                    i_s_tvalid <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(posedge i_clk);
                end else if (pick == 2) begin
                    send_quiet = $urandom_range(20, 60);
                end
            end
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {1'b0, restart, col};
        do @(posedge i_clk); while (!o_s_tready);
        want = derive_column(col, restart);
        if (kind == ROW_FIRST) begin
            want = FIRST_COLUMN;
        end else if (kind == ROW_REJECT) begin
            want     = '0;
            want.col = col;
            want.bad = 1'b1;
        end
        awaited_columns.push_back(want);
        items_sent++;
        calm = (items_sent >= ITEM_TARGET - ITEM_TARGET / 8);
    endtask

    // Drop the request and wait until the block has handed over everything.
    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (awaited_columns.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_K_SOURCE: k_cfg = val;
            REG_S_LDPC:   s_cfg = val[S_W-1:0];
            REG_H_HALF:   h_cfg = val[H_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_setting(input logic [CFG_DAT_W-1:0] k, s, h, input bit spare);
        settle();
        write_reg(REG_K_SOURCE, k);
        write_reg(REG_S_LDPC, s);
        write_reg(REG_H_HALF, h);
        if (spare) begin
            write_reg(REG_SPARE, CFG_DAT_W'($urandom));
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Restart at column zero and climb towards L, salting the climb with
    // random requests, skipped and repeated columns and fresh restarts.
    task automatic walk(input int unsigned budget);
        int unsigned n, pick;
        flowing = 1'b1;
        offer('0, 1'b1, ROW_PREDICT);
        for (n = 1; n < budget; n++) begin
            pick = $urandom_range(0, 99);
            if (expect_col >= frame_len()) begin
                offer(expect_col, 1'b0, ROW_PREDICT);   // one past the end
                break;
            end else if (pick < 3) begin
                offer(COL_W'($urandom), 1'($urandom), ROW_PREDICT);
            end else if (pick < 5) begin
                offer(expect_col + 1'b1, 1'b0, ROW_PREDICT);
            end else if (pick == 5) begin
                offer(expect_col - 1'b1, 1'b0, ROW_PREDICT);
            end else if (pick == 6) begin
                offer('0, 1'b1, ROW_PREDICT);
            end else begin
                offer(expect_col, 1'b0, ROW_PREDICT);
            end
        end
        flowing = 1'b0;
    endtask

    initial begin : stimulus
        int unsigned          pick, p;
        logic [CFG_DAT_W-1:0] k, s, h;
        i_rst_n     <= 1'b0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= REG_K_SOURCE;
        i_cfg_data  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows at the reset register values.
        for (p = 0; p < NUM_PROBES; p++) begin
            offer(PROBES[p].col, PROBES[p].restart, PROBES[p].kind);
        end

        // Extreme settings. S=255 with clipped H=16 drives identity_row past
        // 255 and uses every mask bit; the unused index is written here too.
        load_setting(14'd4, 14'd255, 14'd31, 1'b1);
        walk(400);
        // Oversized K is clipped to the maximum.
        load_setting(14'd16383, 14'd211, 14'd16, 1'b0);
        walk(60);
        // S of zero and one: modulus and step both degenerate.
        load_setting(14'd9, 14'd0, 14'd5, 1'b0);
        walk(40);
        load_setting(14'd7, 14'd1, 14'd1, 1'b0);
        walk(40);
        load_setting(14'd4, 14'd3, 14'd3, 1'b0);
        walk(40);
        // Weight-zero Half word: the second search has to wrap the whole counter.
        load_setting(14'd4, 14'd5, 14'd0, 1'b0);
        flowing = 1'b1;
        offer('0, 1'b1, ROW_PREDICT);
        offer(14'd1, 1'b0, ROW_PREDICT);
        flowing = 1'b0;

        // Random settings, each followed by a walk. Small K dominates so that
        // walks reach the Half and identity parts.
        while (items_sent < ITEM_TARGET) begin
            pick = $urandom_range(0, 19);
            if (pick < 14) begin
                k = CFG_DAT_W'($urandom_range(4, 60));
            end else if (pick < 17) begin
                k = CFG_DAT_W'($urandom_range(61, 400));
            end else if (pick < 19) begin
                k = CFG_DAT_W'($urandom_range(401, 8192));
            end else begin
                k = CFG_DAT_W'($urandom_range(8193, 16383));
            end
            if ($urandom_range(0, 9) < 6) begin
                s = CFG_DAT_W'(LDPC_PRIMES[$urandom_range(0, NUM_PRIMES - 1)]);
            end else begin
                s = CFG_DAT_W'($urandom_range(0, 255));
            end
            if ($urandom_range(0, 9) < 8) begin
                h = CFG_DAT_W'($urandom_range(5, 16));
            end else begin
                h = CFG_DAT_W'($urandom_range(17, 31));
            end
            // Junk above the register width must be ignored.
            if ($urandom_range(0, 7) == 0) begin
                s[CFG_DAT_W-1:S_W] = 6'($urandom);
                h[CFG_DAT_W-1:H_W] = 9'($urandom);
            end
            load_setting(k, s, h, $urandom_range(0, 9) == 0);
            walk($urandom_range(40, 320));
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/rpcg_pkg.sv
rtl/rpcg_divider.sv
rtl/rpcg_gray_search.sv
rtl/raptor_precode_column_generator_unit.sv
test/tb_raptor_precode_column_generator_unit.sv
